@@ sv/slts_pkg.sv @@
package slts_pkg;

  localparam int unsigned PositionBits = 16;
  localparam int unsigned FieldBits    = 16;

  typedef enum logic [2:0] {
    ModeNormal    = 3'd0,
    ModeIdent     = 3'd1,
    ModeNumber    = 3'd2,
    ModeSlash     = 3'd3,
    ModeLine      = 3'd4,
    ModeBlock     = 3'd5,
    ModeBlockStar = 3'd6
  } mode_e;

  typedef enum logic [3:0] {
    KindIdent  = 4'd0,
    KindPrint  = 4'd1,
    KindNumber = 4'd2,
    KindAdd    = 4'd3,
    KindSub    = 4'd4,
    KindMul    = 4'd5,
    KindDiv    = 4'd6,
    KindAssign = 4'd7,
    KindLparen = 4'd8,
    KindRparen = 4'd9,
    KindEof    = 4'd10
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [FieldBits-1:0] line;
    logic [FieldBits-1:0] column;
    logic [FieldBits-1:0] length;
    logic                 last;
  } token_t;

  // Tokens caused by one input byte, in order
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } emit_t;

endpackage

@@ sv/source_lexer_token_scanner.sv @@
// Streaming tokenizer: one source byte per transaction in, tokens (kind, line, start
// column, length, last flag) out. A byte is taken every cycle unless the output side
// holds it back; it sits in the input register, where the scan state and counters
// update, and its tokens appear from the two-entry result register the cycle after.
// A byte that completes a pending token and also starts an operator, or an end-of-input
// that flushes a token, yields two tokens; the next byte that yields tokens waits until
// both have left. Bytes that yield nothing never wait on the output side.
// Line, column and length counters are PositionBits wide and saturate at all ones.
module source_lexer_token_scanner #(
  parameter int unsigned PositionBits = slts_pkg::PositionBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  source_byte_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  token_kind_o,
  output logic [15:0] token_line_o,
  output logic [15:0] token_column_o,
  output logic [15:0] token_length_o,
  output logic        last_of_run_o
);

  logic             ivalid_q, ivalid_d;
  logic [7:0]       byte_q;
  logic             eoi_q;
  logic             advance;
  logic             load_ok;
  logic             accept;
  slts_pkg::emit_t  emit;
  slts_pkg::token_t head;

  assign advance    = ivalid_q && (emit.count == 2'd0 || load_ok);
  assign in_ready_o = !ivalid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    ivalid_d = ivalid_q;
    if (accept) begin
      ivalid_d = 1'b1;
    end else if (advance) begin
      ivalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ivalid_q <= 1'b0;
    end else begin
      ivalid_q <= ivalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= source_byte_i;
      eoi_q  <= end_of_input_i;
    end
  end

  slts_scan #(
    .PositionBits(PositionBits)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .source_byte_i (byte_q),
    .end_of_input_i(eoi_q),
    .emit_o        (emit)
  );

  slts_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && emit.count != 2'd0),
    .emit_i     (emit),
    .load_ok_o  (load_ok),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .head_o     (head)
  );

  assign token_kind_o   = head.kind;
  assign token_line_o   = head.line;
  assign token_column_o = head.column;
  assign token_length_o = head.length;
  assign last_of_run_o  = head.last;

endmodule

@@ sv/slts_scan.sv @@
module slts_scan #(
  parameter int unsigned PositionBits = slts_pkg::PositionBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic [7:0]          source_byte_i,
  input  logic                end_of_input_i,
  output slts_pkg::emit_t     emit_o
);

  typedef logic [PositionBits-1:0] pos_t;

  localparam pos_t       PosMax  = '1;
  localparam pos_t       PosOne  = pos_t'(1);
  localparam logic [2:0] KwLen   = 3'd5;
  localparam logic [2:0] KwFail  = 3'd7;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChUnder   = 8'h5F;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChEqual   = 8'h3D;
  localparam logic [7:0] ChLparen  = 8'h28;
  localparam logic [7:0] ChRparen  = 8'h29;

  slts_pkg::mode_e mode_q, mode_d;
  pos_t            line_q, line_d;
  pos_t            col_q, col_d;
  pos_t            start_q, start_d;
  pos_t            run_q, run_d;
  logic [2:0]      kw_q, kw_d;

  function automatic pos_t sat_inc(pos_t v);
    return (v == PosMax) ? v : v + PosOne;
  endfunction

  function automatic logic [slts_pkg::FieldBits-1:0] to_field(pos_t v);
    logic [PositionBits+slts_pkg::FieldBits-1:0] ext;
    ext = {{slts_pkg::FieldBits{1'b0}}, v};
    return ext[slts_pkg::FieldBits-1:0];
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == ChUnder;
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic [7:0] kw_char(logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h70;  // p
      3'd1:    c = 8'h72;  // r
      3'd2:    c = 8'h69;  // i
      3'd3:    c = 8'h6E;  // n
      3'd4:    c = 8'h74;  // t
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic slts_pkg::token_t mk_tok(slts_pkg::kind_e k, pos_t ln, pos_t cl,
                                              pos_t len);
    slts_pkg::token_t t;
    t.kind   = k;
    t.line   = to_field(ln);
    t.column = to_field(cl);
    t.length = to_field(len);
    t.last   = 1'b0;
    return t;
  endfunction

  slts_pkg::token_t tok_a, tok_b;
  logic             has_a, has_b;
  logic             do_norm;
  pos_t             col_b;
  slts_pkg::kind_e  op_kind;
  logic             is_op;
  pos_t             line_e, col_e;
  pos_t             two_max;
  logic [7:0]       b;

  always_comb begin
    b       = source_byte_i;
    mode_d  = mode_q;
    line_d  = line_q;
    col_d   = col_q;
    start_d = start_q;
    run_d   = run_q;
    kw_d    = kw_q;
    tok_a   = mk_tok(slts_pkg::KindIdent, line_q, start_q, run_q);
    tok_b   = mk_tok(slts_pkg::KindEof, line_q, col_q, '0);
    has_a   = 1'b0;
    has_b   = 1'b0;
    do_norm = 1'b0;
    col_b   = col_q;
    line_e  = line_q;
    col_e   = col_q;
    two_max = PosMax - PosOne;
    op_kind = slts_pkg::KindAdd;
    is_op   = 1'b0;

    if (end_of_input_i) begin
      case (mode_q)
        slts_pkg::ModeIdent: begin
          has_a = 1'b1;
          tok_a = mk_tok((kw_q == KwLen) ? slts_pkg::KindPrint : slts_pkg::KindIdent,
                         line_q, start_q, run_q);
        end
        slts_pkg::ModeNumber: begin
          has_a = 1'b1;
          tok_a = mk_tok(slts_pkg::KindNumber, line_q, start_q, run_q);
        end
        slts_pkg::ModeSlash: begin
          has_a = 1'b1;
          tok_a = mk_tok(slts_pkg::KindDiv, line_q, start_q, PosOne);
          col_e = sat_inc(col_q);
        end
        slts_pkg::ModeLine: begin
          line_e = sat_inc(line_q);
          col_e  = PosOne;
        end
        default: ;
      endcase
      has_b   = 1'b1;
      tok_b   = mk_tok(slts_pkg::KindEof, line_e, col_e, '0);
      // return to the reset state for the next source
      mode_d  = slts_pkg::ModeNormal;
      line_d  = PosOne;
      col_d   = PosOne;
      start_d = '0;
      run_d   = '0;
      kw_d    = '0;
    end else begin
      case (mode_q)
        slts_pkg::ModeIdent: begin
          if (is_letter(b) || is_digit(b)) begin
            if (kw_q < KwLen && pos_t'(kw_q) == run_q && b == kw_char(kw_q)) begin
              kw_d = kw_q + 3'd1;
            end else begin
              kw_d = KwFail;
            end
            run_d = sat_inc(run_q);
            col_d = sat_inc(col_q);
          end else begin
            has_a   = 1'b1;
            tok_a   = mk_tok((kw_q == KwLen) ? slts_pkg::KindPrint : slts_pkg::KindIdent,
                             line_q, start_q, run_q);
            do_norm = 1'b1;
          end
        end
        slts_pkg::ModeNumber: begin
          if (is_digit(b) || b == ChDot) begin
            run_d = sat_inc(run_q);
            col_d = sat_inc(col_q);
          end else begin
            has_a   = 1'b1;
            tok_a   = mk_tok(slts_pkg::KindNumber, line_q, start_q, run_q);
            do_norm = 1'b1;
          end
        end
        slts_pkg::ModeSlash: begin
          if (b == ChSlash) begin
            mode_d = slts_pkg::ModeLine;
          end else if (b == ChStar) begin
            col_d  = (col_q >= two_max) ? PosMax : col_q + pos_t'(2);
            mode_d = slts_pkg::ModeBlock;
          end else begin
            has_a   = 1'b1;
            tok_a   = mk_tok(slts_pkg::KindDiv, line_q, start_q, PosOne);
            col_b   = sat_inc(col_q);
            do_norm = 1'b1;
          end
        end
        slts_pkg::ModeLine: begin
          if (b == ChNewline) begin
            line_d = sat_inc(line_q);
            col_d  = PosOne;
            mode_d = slts_pkg::ModeNormal;
          end
        end
        slts_pkg::ModeBlock, slts_pkg::ModeBlockStar: begin
          if (b == ChNewline) begin
            line_d = sat_inc(line_q);
            col_d  = PosOne;
            mode_d = slts_pkg::ModeBlock;
          end else begin
            col_d = sat_inc(col_q);
            if (b == ChStar) begin
              mode_d = slts_pkg::ModeBlockStar;
            end else if (b == ChSlash && mode_q == slts_pkg::ModeBlockStar) begin
              mode_d = slts_pkg::ModeNormal;
            end else begin
              mode_d = slts_pkg::ModeBlock;
            end
          end
        end
        default: begin
          do_norm = 1'b1;
        end
      endcase

      // start-of-token handling, possibly after a flushed token
      if (do_norm) begin
        mode_d = slts_pkg::ModeNormal;
        col_d  = sat_inc(col_b);
        case (b)
          ChPlus:   begin is_op = 1'b1; op_kind = slts_pkg::KindAdd;    end
          ChMinus:  begin is_op = 1'b1; op_kind = slts_pkg::KindSub;    end
          ChStar:   begin is_op = 1'b1; op_kind = slts_pkg::KindMul;    end
          ChEqual:  begin is_op = 1'b1; op_kind = slts_pkg::KindAssign; end
          ChLparen: begin is_op = 1'b1; op_kind = slts_pkg::KindLparen; end
          ChRparen: begin is_op = 1'b1; op_kind = slts_pkg::KindRparen; end
          default:  ;
        endcase
        if (b == ChNewline) begin
          line_d = sat_inc(line_q);
          col_d  = PosOne;
        end else if (is_letter(b)) begin
          mode_d  = slts_pkg::ModeIdent;
          start_d = col_b;
          run_d   = PosOne;
          kw_d    = (b == kw_char(3'd0)) ? 3'd1 : KwFail;
        end else if (is_digit(b)) begin
          mode_d  = slts_pkg::ModeNumber;
          start_d = col_b;
          run_d   = PosOne;
        end else if (b == ChSlash) begin
          mode_d  = slts_pkg::ModeSlash;
          start_d = col_b;
          col_d   = col_b;
        end else if (is_op) begin
          if (has_a) begin
            has_b = 1'b1;
            tok_b = mk_tok(op_kind, line_q, col_b, PosOne);
          end else begin
            has_a = 1'b1;
            tok_a = mk_tok(op_kind, line_q, col_b, PosOne);
          end
        end
      end
    end
  end

  // pack tokens in order and flag the final one
  always_comb begin
    emit_o = '0;
    if (has_a && has_b) begin
      emit_o.count     = 2'd2;
      emit_o.tok0      = tok_a;
      emit_o.tok1      = tok_b;
      emit_o.tok1.last = 1'b1;
    end else if (has_a) begin
      emit_o.count     = 2'd1;
      emit_o.tok0      = tok_a;
      emit_o.tok0.last = 1'b1;
    end else if (has_b) begin
      emit_o.count     = 2'd1;
      emit_o.tok0      = tok_b;
      emit_o.tok0.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= slts_pkg::ModeNormal;
      line_q  <= PosOne;
      col_q   <= PosOne;
      start_q <= '0;
      run_q   <= '0;
      kw_q    <= '0;
    end else if (advance_i) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      start_q <= start_d;
      run_q   <= run_d;
      kw_q    <= kw_d;
    end
  end

endmodule

@@ sv/slts_outbuf.sv @@
module slts_outbuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  slts_pkg::emit_t  emit_i,
  output logic             load_ok_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output slts_pkg::token_t head_o
);

  logic             v0_q, v0_d;
  logic             v1_q, v1_d;
  slts_pkg::token_t s0_q, s0_d;
  slts_pkg::token_t s1_q, s1_d;
  logic             pop;

  assign pop         = v0_q && out_ready_i;
  // take a new pair once both slots are empty after this cycle's transaction
  assign load_ok_o   = !v0_q || (pop && !v1_q);
  assign out_valid_o = v0_q;
  assign head_o      = s0_q;

  always_comb begin
    v0_d = v0_q;
    v1_d = v1_q;
    s0_d = s0_q;
    s1_d = s1_q;
    if (load_i) begin
      v0_d = 1'b1;
      s0_d = emit_i.tok0;
      v1_d = (emit_i.count == 2'd2);
      s1_d = emit_i.tok1;
    end else if (pop) begin
      v0_d = v1_q;
      s0_d = s1_q;
      v1_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

endmodule
